// ===== hw/rtl/tpw_pkg.sv =====
// Package: shared constants, types and helper functions for the page table walker.
`default_nettype none

package tpw_pkg;

    // Store geometry
    localparam int TABLE_PAGES      = 64;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int STORE_DEPTH      = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int SLOT_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);

    // Field widths
    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int PPN_W      = 44;
    localparam int VA_W       = 39;
    localparam int PA_W       = 56;
    localparam int IN_SLOT_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 44;

    // Page table entry layout
    localparam int PPN_LSB  = 10;
    localparam int PPN_MSB  = PPN_LSB + PPN_W - 1;
    localparam int PAGE_OFS = 12;
    localparam int FLAG_V   = 0;
    localparam int FLAG_R   = 1;
    localparam int FLAG_W   = 2;
    localparam int FLAG_X   = 3;
    localparam int FLAG_U   = 4;

    // Virtual address index fields
    localparam int VPN2_LSB = 30;
    localparam int VPN1_LSB = 21;
    localparam int VPN0_LSB = 12;

    localparam logic [PPN_W-1:0] PAGES_PPN  = PPN_W'(TABLE_PAGES);
    localparam logic [12:0]      PAGES_SLOT = 13'(TABLE_PAGES);

    // Request kinds
    localparam logic REQ_WRITE     = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SLOT  = 1'd1;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_ROOT_INVALID  = 3'd1,
        ST_MID_INVALID   = 3'd2,
        ST_MID_SUPER     = 3'd3,
        ST_LEAF_INVALID  = 3'd4,
        ST_LEAF_NOT_USER = 3'd5,
        ST_OUTSIDE       = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_MID,
        S_LEAF,
        S_FIN
    } t_state;

    // Slot lookup: in-store flag and store page
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } t_slot;

    // Command to the table memory
    typedef struct packed {
        logic               we;
        logic               re;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } t_ram_cmd;

    // Map an entry's PPN to a store page
    function automatic t_slot ptr_slot(input logic [ENTRY_W-1:0] e,
                                       input logic [PPN_W-1:0] base);
        logic [PPN_W:0] diff;
        t_slot          r;
        diff   = {1'b0, e[PPN_MSB:PPN_LSB]} - {1'b0, base};
        r.ok   = !diff[PPN_W] && (diff[PPN_W-1:0] < PAGES_PPN);
        r.slot = diff[SLOT_W-1:0];
        return r;
    endfunction

    // Check a directly given slot number against the store size
    function automatic t_slot slot_fit(input logic [IN_SLOT_W-1:0] s);
        logic [12:0] ext;
        t_slot       r;
        ext    = {7'b0, s};
        r.ok   = ext < PAGES_SLOT;
        r.slot = ext[SLOT_W-1:0];
        return r;
    endfunction

    // Flat store address of an entry
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] full;
        full = {slot, idx};
        return full[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpw_if.sv =====
// Interfaces: request, response and configuration channels of the page table walker.
`default_nettype none

interface tpw_req_if;
    import tpw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [IN_SLOT_W-1:0] table_slot;
    logic [IDX_W-1:0]     entry_index;
    logic [ENTRY_W-1:0]   entry_value;
    logic [VA_W-1:0]      virt_addr;

    modport source (output valid, req_type, table_slot, entry_index, entry_value,
                    virt_addr, input ready);
    modport sink   (input valid, req_type, table_slot, entry_index, entry_value,
                    virt_addr, output ready);
endinterface

interface tpw_rsp_if;
    import tpw_pkg::*;
    logic            valid;
    logic            ready;
    logic [PA_W-1:0] phys_addr;
    logic [2:0]      status;

    modport source (output valid, phys_addr, status, input ready);
    modport sink   (input valid, phys_addr, status, output ready);
endinterface

interface tpw_cfg_if;
    import tpw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpw_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module tpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpw_walker.sv =====
// Walk sequencer: store clearing, entry writes, three-level walk and result register.
`default_nettype none

module tpw_walker
    import tpw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tpw_req_if.sink                 i_req,
    tpw_rsp_if.source               o_rsp,
    input  wire logic [PPN_W-1:0]   i_store_base,
    input  wire logic [IN_SLOT_W-1:0] i_root_slot,
    input  wire logic [ENTRY_W-1:0] i_ram_rdata,
    output t_ram_cmd                o_ram_cmd
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [VPN1_LSB+IDX_W-VPN0_LSB-1:0] r_va_low, n_va_low;
    logic [PA_W-1:0]     r_res_phys, n_res_phys;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [PA_W-1:0]     r_out_phys, n_out_phys;
    t_status             r_out_status, n_out_status;

    logic    accept;
    logic    out_free;
    logic    step_end;
    t_status step_stat;
    t_slot   wr_slot;
    t_slot   root_fit;
    t_slot   ptr;
    logic    ent_v;
    logic    ent_u;
    logic    ent_rwx;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign wr_slot  = slot_fit(i_req.table_slot);
    assign root_fit = slot_fit(i_root_slot);
    assign ptr      = ptr_slot(i_ram_rdata, i_store_base);
    assign ent_v    = i_ram_rdata[FLAG_V];
    assign ent_u    = i_ram_rdata[FLAG_U];
    assign ent_rwx  = i_ram_rdata[FLAG_R] | i_ram_rdata[FLAG_W] | i_ram_rdata[FLAG_X];

    // Judge the current step: does the item end here, and with what status
    always_comb begin
        step_end  = 1'b0;
        step_stat = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req.req_type == REQ_WRITE) begin
                    step_end  = 1'b1;
                    step_stat = wr_slot.ok ? ST_OK : ST_OUTSIDE;
                end else begin
                    step_end  = !root_fit.ok;
                    step_stat = ST_OUTSIDE;
                end
            end
            S_ROOT: begin
                step_end  = !ent_v || !ptr.ok;
                step_stat = !ent_v ? ST_ROOT_INVALID : ST_OUTSIDE;
            end
            S_MID: begin
                step_end = !ent_v || ent_rwx || !ptr.ok;
                if (!ent_v) begin
                    step_stat = ST_MID_INVALID;
                end else if (ent_rwx) begin
                    step_stat = ST_MID_SUPER;
                end else begin
                    step_stat = ST_OUTSIDE;
                end
            end
            S_LEAF: begin
                step_end = 1'b1;
                if (!ent_v) begin
                    step_stat = ST_LEAF_INVALID;
                end else if (!ent_u) begin
                    step_stat = ST_LEAF_NOT_USER;
                end else begin
                    step_stat = ST_OK;
                end
            end
            default: begin
                step_end  = 1'b0;
                step_stat = ST_OK;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = step_end ? S_FIN : S_ROOT;
                end
            end
            S_ROOT:  n_state = step_end ? S_FIN : S_MID;
            S_MID:   n_state = step_end ? S_FIN : S_LEAF;
            S_LEAF:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs: memory commands, result capture and output register
    always_comb begin
        i_req.ready     = 1'b0;
        o_ram_cmd       = '0;
        n_clr_addr      = r_clr_addr;
        n_va_low        = r_va_low;
        n_res_phys      = r_res_phys;
        n_res_status    = r_res_status;
        n_out_valid     = r_out_valid;
        n_out_phys      = r_out_phys;
        n_out_status    = r_out_status;

        // Drop a delivered result
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_ram_cmd.we    = 1'b1;
                o_ram_cmd.addr  = r_clr_addr;
                o_ram_cmd.wdata = '0;
                n_clr_addr      = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_va_low     = i_req.virt_addr[VPN1_LSB+IDX_W-1:VPN0_LSB];
                    n_res_phys   = '0;
                    n_res_status = step_stat;
                    if (i_req.req_type == REQ_WRITE) begin
                        o_ram_cmd.we    = wr_slot.ok;
                        o_ram_cmd.addr  = entry_addr(wr_slot.slot, i_req.entry_index);
                        o_ram_cmd.wdata = i_req.entry_value;
                    end else begin
                        o_ram_cmd.re   = root_fit.ok;
                        o_ram_cmd.addr = entry_addr(root_fit.slot,
                                             i_req.virt_addr[VPN2_LSB+IDX_W-1:VPN2_LSB]);
                    end
                end
            end
            S_ROOT: begin
                n_res_status = step_stat;
                if (!step_end) begin
                    o_ram_cmd.re   = 1'b1;
                    o_ram_cmd.addr = entry_addr(ptr.slot,
                                         r_va_low[VPN1_LSB-VPN0_LSB+IDX_W-1:VPN1_LSB-VPN0_LSB]);
                end
            end
            S_MID: begin
                n_res_status = step_stat;
                if (!step_end) begin
                    o_ram_cmd.re   = 1'b1;
                    o_ram_cmd.addr = entry_addr(ptr.slot, r_va_low[IDX_W-1:0]);
                end
            end
            S_LEAF: begin
                n_res_status = step_stat;
                if (step_stat == ST_OK) begin
                    n_res_phys = {i_ram_rdata[PPN_MSB:PPN_LSB], {PAGE_OFS{1'b0}}};
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_phys   = r_res_phys;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.phys_addr = r_out_phys;
    assign o_rsp.status    = r_out_status;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_va_low     <= n_va_low;
        r_res_phys   <= n_res_phys;
        r_res_status <= n_res_status;
        r_out_phys   <= n_out_phys;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/three_level_page_table_walk.sv =====
// Throughput: one item at a time; a translation is bound by three dependent reads of the
// single-port table memory; a stalled result holds the walker, and the next item is taken
// the cycle after a result is registered.
// Reset: synchronous, active low; afterwards the table store is swept to zero, one entry a
// cycle, with no item accepted; config writes are always taken.
`default_nettype none

module three_level_page_table_walk
    import tpw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpw_req_if.sink   i_req,
    tpw_rsp_if.source o_rsp,
    tpw_cfg_if.sink   i_cfg
);

    logic [PPN_W-1:0]     r_store_base;
    logic [IN_SLOT_W-1:0] r_root_slot;
    t_ram_cmd             ram_cmd;
    logic [ENTRY_W-1:0]   ram_rdata;

    // Take config beats at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_base <= '0;
            r_root_slot  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_STORE_BASE: r_store_base <= i_cfg.wr_data[PPN_W-1:0];
                CFG_ROOT_SLOT:  r_root_slot  <= i_cfg.wr_data[IN_SLOT_W-1:0];
                default:        r_root_slot  <= r_root_slot;
            endcase
        end
    end

    tpw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_store_base (r_store_base),
        .i_root_slot  (r_root_slot),
        .i_ram_rdata  (ram_rdata),
        .o_ram_cmd    (ram_cmd)
    );

    tpw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_re    (ram_cmd.re),
        .i_addr  (ram_cmd.addr),
        .i_wdata (ram_cmd.wdata),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
